### rtl/segment_latch_receiver_defines.svh
// Assertion macros for the checker file.
`ifndef SEGMENT_LATCH_RECEIVER_DEFINES_SVH
`define SEGMENT_LATCH_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SLR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/slr_pkg.sv
`default_nettype none

package slr_pkg;

    localparam int BLOCK_BYTES    = 8;
    localparam int NUM_BLOCKS     = 3;
    localparam int SELECT_SHIFT   = 3;
    localparam int RING_LEN       = BLOCK_BYTES + 1;
    localparam int STORE_LEN      = NUM_BLOCKS * BLOCK_BYTES;
    localparam int SEGMENT_COUNT  = STORE_LEN * 8;
    localparam int BLOCK_MASK_ALL = (1 << NUM_BLOCKS) - 1;

    localparam int RING_AW  = $clog2(RING_LEN);
    localparam int STORE_AW = (STORE_LEN > 1) ? $clog2(STORE_LEN) : 1;
    localparam int BLK_W    = $clog2(NUM_BLOCKS + 1);
    localparam int CNT_W    = $clog2(BLOCK_BYTES + 1);
    localparam int SEG_W    = $clog2(SEGMENT_COUNT + 1);
    localparam int CMP_W    = (SEG_W > 8) ? SEG_W : 8;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_LOAD    = 2'd1,
        OP_READ    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_COPY,
        S_DRAIN,
        S_READ,
        S_RESP
    } state_t;

    // Store write request, registered so that it lines up with the ring read data
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
    } store_wr_t;

endpackage

`default_nettype wire

### rtl/slr_if.sv
`default_nettype none

// Input channel: one transaction per command
interface slr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [7:0] segment_index;

    modport source (output valid, output operation, output rx_byte,
                    output segment_index, input ready);
    modport sink   (input valid, input operation, input rx_byte,
                    input segment_index, output ready);
endinterface

// Output channel: one transaction per command
interface slr_out_if;
    logic        valid;
    logic        ready;
    logic        segment_on;
    logic [15:0] state_version;
    logic [2:0]  blocks_loaded;

    modport source (output valid, output segment_on, output state_version,
                    output blocks_loaded, input ready);
    modport sink   (input valid, input segment_on, input state_version,
                    input blocks_loaded, output ready);
endinterface

`default_nettype wire

### rtl/slr_ram.sv
`default_nettype none

module slr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/segment_latch_receiver.sv
// Receiver for a serial segment display driver. Each input transaction is a
// received byte, a load strobe or a segment read, and each gives exactly one
// output transaction. Bytes go into a ring memory of BLOCK_BYTES+1 entries; a
// load strobe takes the newest byte as the block select (bits 3 and up) and
// copies the BLOCK_BYTES older bytes, oldest first, into each selected block
// of the segment store memory, then rewinds the ring and bumps the 16-bit
// version. A read returns one stored bit, indexed from the far end of the
// store. Commands run one at a time. A load copies each selected block
// through the single write port of the segment store, which takes one byte
// a cycle. A new command is taken while the previous result waits at the
// output register. The store reads as zero after reset with no clearing pass.
`default_nettype none

module segment_latch_receiver
    import slr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    slr_in_if.sink    in_item,
    slr_out_if.source result
);

    state_t              state_reg, state_next;
    logic [RING_AW-1:0]  pos_reg, pos_next;
    logic [15:0]         count_reg, count_next;
    logic [RING_AW-1:0]  start_reg, start_next;
    logic [RING_AW-1:0]  ridx_reg, ridx_next;
    logic [STORE_AW-1:0] saddr_reg, saddr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [7:0]          sel_reg, sel_next;
    logic [7:0]          work_reg, work_next;
    store_wr_t           pend_reg, pend_next;
    logic [STORE_LEN-1:0] valid_reg, valid_next;
    logic                out_valid_reg, out_valid_next;

    logic [STORE_AW-1:0] rdaddr_reg, rdaddr_next;
    logic [2:0]          bit_reg, bit_next;
    logic                inr_reg, inr_next;
    logic                res_seg_reg, res_seg_next;
    logic [2:0]          res_blk_reg, res_blk_next;
    logic                out_seg_reg, out_seg_next;
    logic [15:0]         out_ver_reg, out_ver_next;
    logic [2:0]          out_blk_reg, out_blk_next;

    logic                accept;
    op_t                 op;
    logic                ring_we;
    logic [RING_AW-1:0]  ring_raddr;
    logic [7:0]          ring_rdata;
    logic [7:0]          store_rdata;
    logic [STORE_AW-1:0] store_raddr;
    logic [CMP_W-1:0]    rev_index;
    logic [RING_AW-1:0]  newest;
    logic [7:0]          sel_byte;

    assign in_item.ready = (state_reg == S_IDLE);
    assign accept        = in_item.valid && in_item.ready;
    assign op            = op_t'(in_item.operation);

    assign result.valid         = out_valid_reg;
    assign result.segment_on    = out_seg_reg;
    assign result.state_version = out_ver_reg;
    assign result.blocks_loaded = out_blk_reg;

    // Reverse the segment index and split it into byte address and bit
    assign rev_index   = CMP_W'(SEGMENT_COUNT - 1) - CMP_W'(in_item.segment_index);
    assign store_raddr = STORE_AW'(rev_index >> 3);
    assign newest      = (pos_reg == '0) ? RING_AW'(RING_LEN - 1) : pos_reg - 1'b1;
    assign sel_byte    = (ring_rdata >> SELECT_SHIFT) & 8'(BLOCK_MASK_ALL);

    assign ring_we    = accept && (op == OP_RX_BYTE);
    assign ring_raddr = (state_reg == S_IDLE) ? newest : ridx_reg;

    slr_ram #(
        .WIDTH (8),
        .DEPTH (RING_LEN)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (pos_reg),
        .wdata (in_item.rx_byte),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    slr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_LEN)
    ) u_store (
        .clk   (clk),
        .we    (pend_reg.en),
        .waddr (pend_reg.addr),
        .wdata (ring_rdata),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // Sequence the commands and build the result
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        ridx_next    = ridx_reg;
        saddr_next   = saddr_reg;
        cnt_next     = cnt_reg;
        blk_next     = blk_reg;
        sel_next     = sel_reg;
        work_next    = work_reg;
        pend_next    = '0;
        valid_next   = valid_reg;
        rdaddr_next  = rdaddr_reg;
        bit_next     = bit_reg;
        inr_next     = inr_reg;
        res_seg_next = res_seg_reg;
        res_blk_next = res_blk_reg;
        out_seg_next = out_seg_reg;
        out_ver_next = out_ver_reg;
        out_blk_next = out_blk_reg;
        out_valid_next = out_valid_reg && !result.ready;

        // Mark store entries written
        if (pend_reg.en)
        begin
            valid_next[pend_reg.addr] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_seg_next = 1'b0;
                    res_blk_next = '0;
                    case (op)
                        OP_RX_BYTE:
                        begin
                            pos_next   = (pos_reg == RING_AW'(RING_LEN - 1)) ? '0
                                                                           : pos_reg + 1'b1;
                            state_next = S_RESP;
                        end
                        OP_LOAD:
                        begin
                            start_next = pos_reg;
                            state_next = S_SEL;
                        end
                        OP_READ:
                        begin
                            rdaddr_next = store_raddr;
                            bit_next    = rev_index[2:0];
                            inr_next    = CMP_W'(in_item.segment_index) < CMP_W'(SEGMENT_COUNT);
                            state_next  = S_READ;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SEL:
            begin
                sel_next   = sel_byte;
                work_next  = sel_byte;
                blk_next   = '0;
                cnt_next   = '0;
                ridx_next  = start_reg;
                saddr_next = '0;
                state_next = S_COPY;
            end

            S_COPY:
            begin
                if (work_reg[0])
                begin
                    // Read the ring byte now, write it to the store next cycle
                    pend_next.en   = 1'b1;
                    pend_next.addr = saddr_reg;
                    saddr_next     = saddr_reg + 1'b1;
                    if (cnt_reg == CNT_W'(BLOCK_BYTES - 1))
                    begin
                        cnt_next  = '0;
                        ridx_next = start_reg;
                        work_next = work_reg >> 1;
                        blk_next  = blk_reg + 1'b1;
                        if (blk_reg == BLK_W'(NUM_BLOCKS - 1))
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                    else
                    begin
                        cnt_next  = cnt_reg + 1'b1;
                        ridx_next = (ridx_reg == RING_AW'(RING_LEN - 1)) ? '0
                                                                        : ridx_reg + 1'b1;
                    end
                end
                else
                begin
                    // Skip an unselected block
                    saddr_next = saddr_reg + STORE_AW'(BLOCK_BYTES);
                    work_next  = work_reg >> 1;
                    blk_next   = blk_reg + 1'b1;
                    if (blk_reg == BLK_W'(NUM_BLOCKS - 1))
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end

            S_DRAIN:
            begin
                pos_next     = '0;
                count_next   = count_reg + 1'b1;
                res_blk_next = sel_reg[2:0];
                state_next   = S_RESP;
            end

            S_READ:
            begin
                res_seg_next = inr_reg && valid_reg[rdaddr_reg] && store_rdata[bit_reg];
                state_next   = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_seg_next   = res_seg_reg;
                    out_ver_next   = count_reg;
                    out_blk_next   = res_blk_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            cnt_reg       <= '0;
            blk_reg       <= '0;
            work_reg      <= '0;
            pend_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            blk_reg       <= blk_next;
            work_reg      <= work_next;
            pend_reg      <= pend_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        start_reg   <= start_next;
        ridx_reg    <= ridx_next;
        saddr_reg   <= saddr_next;
        sel_reg     <= sel_next;
        rdaddr_reg  <= rdaddr_next;
        bit_reg     <= bit_next;
        inr_reg     <= inr_next;
        res_seg_reg <= res_seg_next;
        res_blk_reg <= res_blk_next;
        out_seg_reg <= out_seg_next;
        out_ver_reg <= out_ver_next;
        out_blk_reg <= out_blk_next;
    end

endmodule

`default_nettype wire

### rtl/slr_checker.sv
`default_nettype none

`include "segment_latch_receiver_defines.svh"

module slr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_segment_on,
    input wire logic [15:0] out_state_version,
    input wire logic [2:0]  out_blocks_loaded
);

    // A stalled result holds its payload
    `SLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_state_version) && $stable(out_segment_on) && $stable(out_blocks_loaded), "stalled result changed")

    // One command at a time: busy right after a transaction is taken
    `SLR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")

    // A result is a read or a load, never both
    `SLR_ASSERT_NOW(a_read_or_load, out_valid && (out_blocks_loaded != 3'd0), !out_segment_on, "segment bit set on a load result")

endmodule

bind segment_latch_receiver slr_checker u_slr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_item.valid),
    .in_ready          (in_item.ready),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .out_segment_on    (result.segment_on),
    .out_state_version (result.state_version),
    .out_blocks_loaded (result.blocks_loaded)
);

`default_nettype wire

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slr_pkg::*;

    typedef struct {
        op_t        op;
        logic [7:0] rx;
        logic [7:0] idx;
    } command_t;

    typedef struct {
        logic        seg;
        logic [15:0] version;
        logic [2:0]  mask;
    } display_result_t;

    localparam int ITEMS_PER_PHASE = 185;

    logic clk;
    logic rst_n;

    slr_in_if  in_ch ();
    slr_out_if out_ch ();

    segment_latch_receiver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_ch),
        .result  (out_ch)
    );

    // Stimulus and expectations
    command_t        command_queue [$];
    display_result_t pending_results [$];
    int              sender_idle_pct;
    int              receiver_stall_pct;
    int              error_count;
    int              queued_count;

    // Shadow of the display receiver state
    logic [7:0]  ring_shadow [RING_LEN];
    int          ring_slot;
    logic [7:0]  seg_shadow [STORE_LEN];
    logic [15:0] version_shadow;

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Apply one accepted command to the shadow state and return its result
    function automatic display_result_t apply_command(op_t op, logic [7:0] rx,
                                                      logic [7:0] idx);
        display_result_t res;
        int start;
        int newest;
        int mask;
        int pos;
        res.seg  = 1'b0;
        res.mask = 3'd0;
        case (op)
            OP_RX_BYTE:
            begin
                ring_shadow[ring_slot] = rx;
                ring_slot = (ring_slot + 1) % RING_LEN;
            end
            OP_LOAD:
            begin
                start  = ring_slot;
                newest = (start != 0 ? start : RING_LEN) - 1;
                mask   = (ring_shadow[newest] >> SELECT_SHIFT) & BLOCK_MASK_ALL;
                for (int blk = 0; blk < NUM_BLOCKS; blk++)
                begin
                    if (mask[blk])
                    begin
                        for (int i = 0; i < BLOCK_BYTES; i++)
                            seg_shadow[blk * BLOCK_BYTES + i] =
                                ring_shadow[(start + i) % RING_LEN];
                    end
                end
                ring_slot = 0;
                version_shadow = version_shadow + 16'd1;
                res.mask = mask[2:0];
            end
            OP_READ:
            begin
                // Segments are numbered from the far end of the store
                if (idx < SEGMENT_COUNT)
                begin
                    pos = SEGMENT_COUNT - 1 - idx;
                    res.seg = seg_shadow[pos / 8][pos % 8];
                end
            end
            default:
            begin
            end
        endcase
        res.version = version_shadow;
        return res;
    endfunction

    task automatic add_command(input op_t op, input logic [7:0] rx, input logic [7:0] idx);
        command_t c;
        c.op  = op;
        c.rx  = rx;
        c.idx = idx;
        command_queue.push_back(c);
        queued_count++;
    endtask

    function automatic logic [7:0] random_index();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(SEGMENT_COUNT, 255));
        return 8'($urandom_range(0, SEGMENT_COUNT - 1));
    endfunction

    // Queue one frame: mostly a byte run, a load strobe and some reads
    task automatic add_frame();
        int n;
        if ($urandom_range(0, 99) < 75)
        begin
            n = ($urandom_range(0, 9) < 7) ? BLOCK_BYTES : $urandom_range(0, 12);
            for (int i = 0; i < n; i++)
                add_command(OP_RX_BYTE, 8'($urandom), 8'($urandom));
            add_command(OP_RX_BYTE, 8'($urandom), 8'($urandom));
            add_command(OP_LOAD, 8'($urandom), 8'($urandom));
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                add_command(OP_READ, 8'($urandom), random_index());
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_command(op_t'($urandom_range(0, 3)), 8'($urandom), random_index());
        end
    endtask

    // Poll away from the active edge so queue and handshake updates have settled
    task automatic wait_drained();
        while (command_queue.size() != 0 || in_ch.valid || pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("tb: errors");
        $finish;
    end

    // Send commands: model the accepted transaction, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin : drive_commands
        command_t c;
        display_result_t res;
        if (!rst_n)
        begin
            in_ch.valid         <= 1'b0;
            in_ch.operation     <= OP_NONE;
            in_ch.rx_byte       <= 8'h00;
            in_ch.segment_index <= 8'h00;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                res = apply_command(op_t'(in_ch.operation), in_ch.rx_byte,
                                    in_ch.segment_index);
                pending_results.push_back(res);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (command_queue.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    c = command_queue.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.operation     <= c.op;
                    in_ch.rx_byte       <= c.rx;
                    in_ch.segment_index <= c.idx;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result channel at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin : check_results
        display_result_t exp_res;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing expected");
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (out_ch.segment_on !== exp_res.seg)
                    report_mismatch($sformatf("segment_on %b, expected %b",
                                              out_ch.segment_on, exp_res.seg));
                if (out_ch.state_version !== exp_res.version)
                    report_mismatch($sformatf("state_version %0d, expected %0d",
                                              out_ch.state_version, exp_res.version));
                if (out_ch.blocks_loaded !== exp_res.mask)
                    report_mismatch($sformatf("blocks_loaded %b, expected %b",
                                              out_ch.blocks_loaded, exp_res.mask));
            end
        end
    end

    initial
    begin
        error_count        = 0;
        queued_count       = 0;
        ring_slot          = 0;
        version_shadow     = 16'd0;
        sender_idle_pct    = 19;
        receiver_stall_pct = 66;
        for (int i = 0; i < STORE_LEN; i++)
            seg_shadow[i] = 8'h00;
        for (int i = 0; i < RING_LEN; i++)
            ring_shadow[i] = 8'h00;

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Read the cleared store, then fill the whole ring before any load
        add_command(OP_READ, 8'h00, 8'd0);
        add_command(OP_RX_BYTE, 8'hFF, 8'h00);
        add_command(OP_RX_BYTE, 8'h00, 8'hFF);
        add_command(OP_RX_BYTE, 8'hA5, 8'h00);
        add_command(OP_RX_BYTE, 8'h5A, 8'h00);
        add_command(OP_RX_BYTE, 8'h01, 8'h00);
        add_command(OP_RX_BYTE, 8'h80, 8'h00);
        add_command(OP_RX_BYTE, 8'h7F, 8'h00);
        add_command(OP_RX_BYTE, 8'hFE, 8'h00);
        // Select all blocks; the bits above the block count are ignored
        add_command(OP_RX_BYTE, 8'hF8, 8'h00);
        add_command(OP_LOAD, 8'h00, 8'h00);
        // First and last segments, then indexes past the end
        add_command(OP_READ, 8'h00, 8'd0);
        add_command(OP_READ, 8'h00, 8'd191);
        add_command(OP_READ, 8'h00, 8'd192);
        add_command(OP_READ, 8'h00, 8'd255);
        add_command(OP_NONE, 8'($urandom), 8'($urandom));
        // Load again on a rewound ring: select comes from the last slot
        add_command(OP_LOAD, 8'h00, 8'h00);
        // Short run: the ring rotation must be undone, block 0 only
        add_command(OP_RX_BYTE, 8'h11, 8'h00);
        add_command(OP_RX_BYTE, 8'h22, 8'h00);
        add_command(OP_RX_BYTE, 8'h08, 8'h00);
        add_command(OP_LOAD, 8'h00, 8'h00);
        add_command(OP_READ, 8'h00, 8'd128);
        add_command(OP_READ, 8'h00, 8'd191);
        add_command(OP_READ, 8'h00, 8'd64);

        // Random phases with changing idle patterns
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 19;
                    receiver_stall_pct = 66;
                end
                1:
                begin
                    sender_idle_pct    = 66;
                    receiver_stall_pct = 19;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            while (queued_count < ITEMS_PER_PHASE * (phase + 1))
                add_frame();
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### segment_latch_receiver.f
+incdir+rtl
rtl/slr_pkg.sv
rtl/slr_if.sv
rtl/slr_ram.sv
rtl/segment_latch_receiver.sv
rtl/slr_checker.sv
tb/tb.sv
